// ===== rtl/tmr_pkg.sv =====
// shared types, constants and helpers for the thresholded rgb median filter
package tmr_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CFG_W = 16;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    localparam logic [7:0]  THRESH_RST = 8'd1;
    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [10:0] out_col;
        logic [15:0] out_row;
        logic        frame_done;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

endpackage

// ===== rtl/tmr_filter.sv =====
// 3x3 median with threshold switch, three channels in parallel
module tmr_filter (
    input  tmr_pkg::t_rgb       i_win [9],
    input  logic [7:0]          i_thresh,
    output tmr_pkg::t_rgb       o_pix
);

    function automatic logic [7:0] chan_filt(input logic [7:0] v [9],
                                             input logic [7:0] th);
        logic [7:0] mx0, mx1, mx2, md0, md1, md2, mn0, mn1, mn2;
        logic [7:0] med, cen, diff;
        // row sort, then median of maxes/medians/mins gives the exact median of nine
        mn0 = tmr_pkg::min3(v[0], v[1], v[2]);
        md0 = tmr_pkg::med3(v[0], v[1], v[2]);
        mx0 = tmr_pkg::max3(v[0], v[1], v[2]);
        mn1 = tmr_pkg::min3(v[3], v[4], v[5]);
        md1 = tmr_pkg::med3(v[3], v[4], v[5]);
        mx1 = tmr_pkg::max3(v[3], v[4], v[5]);
        mn2 = tmr_pkg::min3(v[6], v[7], v[8]);
        md2 = tmr_pkg::med3(v[6], v[7], v[8]);
        mx2 = tmr_pkg::max3(v[6], v[7], v[8]);
        med = tmr_pkg::med3(tmr_pkg::max3(mn0, mn1, mn2),
                            tmr_pkg::med3(md0, md1, md2),
                            tmr_pkg::min3(mx0, mx1, mx2));
        cen = v[4];
        diff = (cen > med) ? cen - med : med - cen;
        return (diff > th) ? med : cen;
    endfunction

    logic [7:0] w_r [9];
    logic [7:0] w_g [9];
    logic [7:0] w_b [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_r[k] = i_win[k].r;
            w_g[k] = i_win[k].g;
            w_b[k] = i_win[k].b;
        end
        o_pix.r = chan_filt(w_r, i_thresh);
        o_pix.g = chan_filt(w_g, i_thresh);
        o_pix.b = chan_filt(w_b, i_thresh);
    end

endmodule

// ===== rtl/thresholded_median3x3_rgb.sv =====
// top level of the thresholded 3x3 rgb median filter
// Switching 3x3 median filter for raster-order rgb pixels, per channel. A pixel
// request is taken when i_valid and o_ready are high; results leave on o_valid /
// i_ready with their column and row, frame_done set on the frame's last pixel.
// Results of row y appear once row y+1 arrives; during the last row each
// request yields up to two results of the row above plus two of its own. One
// request per clock is sustained while i_ready is high; a request with several
// results holds the input until the last is emitted, as the single median unit
// produces at most one result per clock. Requests pass the input stage and the
// window registers before the output register. Two line memories of MAX_WIDTH
// pixels hold the upper rows and need no clearing pass. The user must write
// configuration (threshold, width, height) only while idle; the block never checks.
module thresholded_median3x3_rgb #(
    parameter int MAX_WIDTH = tmr_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  tmr_pkg::t_pix_in         i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output tmr_pkg::t_pix_out        o_data,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [tmr_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = (CW + 1 > 12) ? CW + 1 : 12;
    localparam logic [FW-1:0] MAXW = FW'(MAX_WIDTH);

    // configuration registers
    logic [7:0]  r_thresh;
    logic [11:0] r_fwidth;
    logic [15:0] r_fheight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= tmr_pkg::THRESH_RST;
            r_fwidth  <= tmr_pkg::WIDTH_RST;
            r_fheight <= tmr_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tmr_pkg::REG_THRESHOLD: r_thresh  <= i_cfg_data[7:0];
                tmr_pkg::REG_WIDTH:     r_fwidth  <= i_cfg_data[11:0];
                tmr_pkg::REG_HEIGHT:    r_fheight <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // clamped geometry and current coordinates
    logic [FW-1:0] fw_ext;
    logic [CW-1:0] wm1;
    logic [15:0]   hm1;
    logic [CW-1:0] r_col_cnt;
    logic [15:0]   r_row_cnt;
    logic [CW-1:0] c_now;
    logic [15:0]   row_now;
    logic          lastcol_now;
    logic          lastrow_now;

    always_comb begin
        fw_ext = FW'(r_fwidth);
        if (fw_ext == '0) begin
            wm1 = '0;
        end else if (fw_ext > MAXW) begin
            wm1 = CW'(MAXW - FW'(1));
        end else begin
            wm1 = CW'(fw_ext - FW'(1));
        end
        hm1 = (r_fheight == 16'd0) ? 16'd0 : r_fheight - 16'd1;
        c_now = (r_col_cnt > wm1) ? wm1 : r_col_cnt;
        row_now = (r_row_cnt > hm1) ? hm1 : r_row_cnt;
        lastcol_now = (c_now == wm1);
        lastrow_now = (row_now == hm1);
    end

    // handshake control
    logic       in_acc;
    logic       a_adv;
    logic       job_free;
    logic       emit;
    logic       r_av;
    logic [3:0] r_jmask;
    logic       r_ov;

    assign emit = (r_jmask != 4'd0) && (!r_ov || i_ready);
    assign job_free = (r_jmask == 4'd0) || (emit && $onehot(r_jmask));
    assign a_adv = r_av && job_free;
    assign o_ready = !r_av || job_free;
    assign in_acc = i_valid && o_ready;

    // coordinate counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (in_acc) begin
            if (lastcol_now) begin
                r_col_cnt <= '0;
                r_row_cnt <= lastrow_now ? 16'd0 : row_now + 16'd1;
            end else begin
                r_col_cnt <= c_now + CW'(1);
                r_row_cnt <= row_now;
            end
        end
    end

    // line memories: middle row written on request, upper row gets the old middle
    logic [23:0] mem_mid [MAX_WIDTH];
    logic [23:0] mem_up  [MAX_WIDTH];
    logic [23:0] r_up;
    logic [23:0] r_mid;
    logic [23:0] r_apx;
    logic [CW-1:0] r_ac;
    logic [15:0]   r_ar;
    logic          r_alc;
    logic          r_alr;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid <= mem_mid[c_now];
            mem_mid[c_now] <= i_data;
            // forward the upper write landing on the same column this edge
            r_up <= (a_adv && (r_ac == c_now)) ? r_mid : mem_up[c_now];
            r_apx <= i_data;
            r_ac  <= c_now;
            r_ar  <= row_now;
            r_alc <= lastcol_now;
            r_alr <= lastrow_now;
        end
        if (a_adv) begin
            mem_up[r_ac] <= r_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (in_acc) begin
            r_av <= 1'b1;
        end else if (a_adv) begin
            r_av <= 1'b0;
        end
    end

    // window and pending result list
    tmr_pkg::t_rgb r_win [3][3];
    logic [CW-1:0] r_jc;
    logic [15:0]   r_jr;
    logic          r_jc0;
    logic          r_jc1;
    logic          r_jr0;
    logic          r_jr1;
    logic [3:0]    n_jmask;
    logic [3:0]    sel;

    // lowest pending bit: upper row left, upper row right, own row left, own row right
    assign sel = r_jmask & (~r_jmask + 4'd1);

    always_comb begin
        n_jmask = r_jmask;
        if (emit) begin
            n_jmask = r_jmask & ~sel;
        end
        if (a_adv) begin
            n_jmask[0] = (r_ar != 16'd0) && (r_ac != '0);
            n_jmask[1] = (r_ar != 16'd0) && r_alc;
            n_jmask[2] = r_alr && (r_ac != '0);
            n_jmask[3] = r_alr && r_alc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jmask <= 4'd0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_jmask <= n_jmask;
            if (a_adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= r_up;
                r_win[1][2] <= r_mid;
                r_win[2][2] <= r_apx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_jc  <= r_ac;
            r_jr  <= r_ar;
            r_jc0 <= (r_ac == '0);
            r_jc1 <= (r_ac == CW'(1));
            r_jr0 <= (r_ar == 16'd0);
            r_jr1 <= (r_ar == 16'd1);
        end
    end

    // window selection with edge clamping for the chosen result
    logic [1:0]    rs [3];
    logic [1:0]    cs [3];
    tmr_pkg::t_rgb sel_win [9];
    tmr_pkg::t_rgb filt;
    logic [CW-1:0] ox;
    logic [15:0]   oy;
    logic          odone;
    logic [CW+10:0] ox_ext;

    always_comb begin
        if (sel[0] || sel[1]) begin
            rs[0] = r_jr1 ? 2'd1 : 2'd0;
            rs[1] = 2'd1;
            rs[2] = 2'd2;
            oy = r_jr - 16'd1;
        end else begin
            rs[0] = r_jr0 ? 2'd2 : 2'd1;
            rs[1] = 2'd2;
            rs[2] = 2'd2;
            oy = r_jr;
        end
        if (sel[0] || sel[2]) begin
            cs[0] = r_jc1 ? 2'd1 : 2'd0;
            cs[1] = 2'd1;
            cs[2] = 2'd2;
            ox = r_jc - CW'(1);
        end else begin
            cs[0] = r_jc0 ? 2'd2 : 2'd1;
            cs[1] = 2'd2;
            cs[2] = 2'd2;
            ox = r_jc;
        end
        odone = sel[3];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sel_win[i*3+j] = r_win[rs[i]][cs[j]];
            end
        end
        ox_ext = (CW+11)'(ox);
    end

    tmr_filter u_filter (
        .i_win    (sel_win),
        .i_thresh (r_thresh),
        .o_pix    (filt)
    );

    // result register
    tmr_pkg::t_pix_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.red_out    <= filt.r;
            r_out.green_out  <= filt.g;
            r_out.blue_out   <= filt.b;
            r_out.out_col    <= ox_ext[10:0];
            r_out.out_row    <= oy;
            r_out.frame_done <= odone;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

`ifndef SYNTH
    // window must not move while results of the previous pixel are still pending
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_jmask != 4'd0) && !emit) |-> !a_adv)
        else $error("window advanced with results pending");

    // an accepted request always lands in the input stage
    a_land: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_av)
        else $error("accepted request lost");

    // frame end is only flagged for the last result of the own-row pass
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && sel[3]) |-> $onehot(r_jmask))
        else $error("frame end not last result");
`endif

endmodule

// ===== bench/thresholded_median3x3_rgb_tb.sv =====
// self-checking bench for the thresholded 3x3 rgb median filter
module thresholded_median3x3_rgb_tb;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    tmr_pkg::t_pix_in             i_data;
    logic                         o_valid;
    logic                         i_ready;
    tmr_pkg::t_pix_out            o_data;
    logic                         i_cfg_we;
    logic [1:0]                   i_cfg_idx;
    logic [tmr_pkg::CFG_W-1:0]    i_cfg_data;

    thresholded_median3x3_rgb u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam int STORE_DEPTH = tmr_pkg::MAX_WIDTH_DEF;
    localparam int STALL_LIMIT = 20000;

    // predictor state: line stores, 3x3 window, raster counters, registers
    tmr_pkg::t_rgb upper_line [STORE_DEPTH];
    tmr_pkg::t_rgb middle_line [STORE_DEPTH];
    tmr_pkg::t_rgb win [3][3];
    int unsigned   col_cnt;
    int unsigned   row_cnt;
    logic [7:0]    thresh;
    logic [11:0]   width_reg;
    logic [15:0]   height_reg;

    tmr_pkg::t_pix_out pending_pix [$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    // directed row: pixel plus optional typed-in expectation of its last result
    typedef struct {
        tmr_pkg::t_pix_in  pix;
        bit                has_fixed;
        tmr_pkg::t_pix_out fixed;
    } t_dir_row;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [7:0] chan_med_sel(input logic [7:0] v[9], input logic [7:0] th);
        logic [7:0] s[9];
        logic [7:0] t;
        logic [7:0] med;
        logic [7:0] cen;
        logic [7:0] diff;
        s = v;
        for (int i = 1; i < 9; i++) begin
            for (int j = i; j > 0; j--) begin
                if (s[j-1] > s[j]) begin
                    t = s[j]; s[j] = s[j-1]; s[j-1] = t;
                end
            end
        end
        med = s[4];
        cen = v[4];
        diff = (cen > med) ? cen - med : med - cen;
        return (diff > th) ? med : cen;
    endfunction

    function automatic tmr_pkg::t_rgb filter_window(input int rs[3], input int cs[3]);
        logic [7:0] vr[9];
        logic [7:0] vg[9];
        logic [7:0] vb[9];
        tmr_pkg::t_rgb res;
        int n;
        n = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                vr[n] = win[rs[i]][cs[j]].r;
                vg[n] = win[rs[i]][cs[j]].g;
                vb[n] = win[rs[i]][cs[j]].b;
                n++;
            end
        end
        res.r = chan_med_sel(vr, thresh);
        res.g = chan_med_sel(vg, thresh);
        res.b = chan_med_sel(vb, thresh);
        return res;
    endfunction

    function automatic tmr_pkg::t_pix_out make_out(input tmr_pkg::t_rgb px,
                                                   input int unsigned x,
                                                   input int unsigned y, input bit done);
        tmr_pkg::t_pix_out o;
        o.red_out = px.r;
        o.green_out = px.g;
        o.blue_out = px.b;
        o.out_col = x[10:0];
        o.out_row = y[15:0];
        o.frame_done = done;
        return o;
    endfunction

    // advance the filter model by one pixel, queue the results it causes
    task automatic predict_pixel(input tmr_pkg::t_pix_in pin);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned y;
        tmr_pkg::t_rgb px;
        tmr_pkg::t_rgb up;
        tmr_pkg::t_rgb mid;
        bit lastcol;
        bit lastrow;
        int rs[3];
        int cs[3];
        w = width_reg;
        h = height_reg;
        if (w == 0) w = 1;
        if (w > STORE_DEPTH) w = STORE_DEPTH;
        if (h == 0) h = 1;
        c = (col_cnt > w - 1) ? w - 1 : col_cnt;
        r = (row_cnt > h - 1) ? h - 1 : row_cnt;
        px = '{pin.red_in, pin.green_in, pin.blue_in};
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = px;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = px;
        lastcol = (c == w - 1);
        lastrow = (r == h - 1);
        for (int p = 0; p < 2; p++) begin
            if (p == 0 && r == 0) continue;
            if (p == 1 && !lastrow) continue;
            if (p == 0) begin
                y = r - 1;
                rs = '{(y == 0) ? 1 : 0, 1, 2};
            end else begin
                y = r;
                rs = '{(y == 0) ? 2 : 1, 2, 2};
            end
            if (c >= 1) begin
                cs = '{(c - 1 == 0) ? 1 : 0, 1, 2};
                pending_pix.push_back(make_out(filter_window(rs, cs), c - 1, y, 1'b0));
            end
            if (lastcol) begin
                cs = '{(c == 0) ? 2 : 1, 2, 2};
                pending_pix.push_back(make_out(filter_window(rs, cs), c, y, p == 1));
            end
        end
        if (lastcol) begin
            col_cnt = 0;
            row_cnt = lastrow ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    // one register write, with i_cfg_we dropped after it so writes never touch back to back
    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[tmr_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tmr_pkg::REG_THRESHOLD: thresh = val[7:0];
            tmr_pkg::REG_WIDTH:     width_reg = val[11:0];
            tmr_pkg::REG_HEIGHT:    height_reg = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drain results and let the median pipe settle before touching registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // hold one pixel request until accepted, with random leading gaps
    task automatic send_pixel(input tmr_pkg::t_pix_in pin);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= pin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_pixel(pin);
    endtask

    function automatic tmr_pkg::t_pix_in rand_pix(input int mode);
        tmr_pkg::t_pix_in p;
        p = 24'($urandom);
        // mostly smooth content with occasional impulses, so both paths fire
        if (mode == 1) begin
            p.red_in = 8'(8'd100 + $urandom_range(6, 0));
            p.green_in = 8'(8'd50 + $urandom_range(6, 0));
            p.blue_in = 8'(8'd200 + $urandom_range(6, 0));
            if ($urandom_range(5, 0) == 0) p.red_in = $urandom_range(1, 0) ? 8'hff : 8'h00;
            if ($urandom_range(5, 0) == 0) p.green_in = $urandom_range(1, 0) ? 8'hff : 8'h00;
            if ($urandom_range(5, 0) == 0) p.blue_in = $urandom_range(1, 0) ? 8'hff : 8'h00;
        end
        return p;
    endfunction

    // result checker: compares each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        tmr_pkg::t_pix_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pix.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                errors++;
            end else begin
                want = pending_pix.pop_front();
                if (o_data !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, o_data);
                    $display("    col %0d/%0d row %0d/%0d done %b/%b",
                             want.out_col, o_data.out_col, want.out_row, o_data.out_row,
                             want.frame_done, o_data.frame_done);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // watchdog: cycles with no accepted request or result
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("thresholded_median3x3_rgb test failed");
                $finish;
            end
        end
    end

    task automatic run_frame(input int unsigned w, input int unsigned h, input int mode);
        for (int i = 0; i < w * h; i++) send_pixel(rand_pix(mode));
        wait_idle();
    endtask

    initial begin
        t_dir_row dir [$];
        t_dir_row row;
        int sent;
        int unsigned w;
        int unsigned h;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tmr_pkg::REG_THRESHOLD;
        i_cfg_data = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        thresh = tmr_pkg::THRESH_RST;
        width_reg = tmr_pkg::WIDTH_RST;
        height_reg = tmr_pkg::HEIGHT_RST;
        col_cnt = 0;
        row_cnt = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 1x1 frame, each pixel is the whole frame and comes back as is
        write_reg(tmr_pkg::REG_WIDTH, 1);
        write_reg(tmr_pkg::REG_HEIGHT, 1);
        write_reg(tmr_pkg::REG_THRESHOLD, 0);
        row.has_fixed = 1;
        row.pix = '{8'h00, 8'h00, 8'h00};
        row.fixed = '{8'h00, 8'h00, 8'h00, 11'd0, 16'd0, 1'b1};
        dir.push_back(row);
        row.pix = '{8'hff, 8'hff, 8'hff};
        row.fixed = '{8'hff, 8'hff, 8'hff, 11'd0, 16'd0, 1'b1};
        dir.push_back(row);
        row.pix = '{8'haa, 8'h55, 8'h81};
        row.fixed = '{8'haa, 8'h55, 8'h81, 11'd0, 16'd0, 1'b1};
        dir.push_back(row);
        foreach (dir[k]) begin
            send_pixel(dir[k].pix);
            if (dir[k].has_fixed && pending_pix[$] !== dir[k].fixed) begin
                $display("%0t: mismatch expected %h actual %h", $time, dir[k].fixed,
                         pending_pix[$]);
                errors++;
            end
        end
        wait_idle();

        // directed: 4x4 frame, flat field with outliers at two corners, an edge and inside
        write_reg(tmr_pkg::REG_WIDTH, 4);
        write_reg(tmr_pkg::REG_HEIGHT, 4);
        write_reg(tmr_pkg::REG_THRESHOLD, 10);
        for (int k = 0; k < 16; k++) begin
            tmr_pkg::t_pix_in p;
            p = '{8'd80, 8'd80, 8'd80};
            if (k == 0) p = '{8'hff, 8'h00, 8'hff};
            if (k == 5) p = '{8'h00, 8'hff, 8'h58};
            if (k == 7) p = '{8'd90, 8'd91, 8'd70};
            if (k == 15) p = '{8'hff, 8'hff, 8'hff};
            send_pixel(p);
        end
        wait_idle();

        // random: varied sizes, thresholds and idling phases
        sent = 0;
        for (int ph = 0; sent < 180; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 45; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 45; end
                default: begin send_idle_pct = 31; recv_idle_pct = 31; end
            endcase
            w = $urandom_range(9, 1);
            h = $urandom_range(6, 1);
            write_reg(tmr_pkg::REG_WIDTH, w);
            write_reg(tmr_pkg::REG_HEIGHT, h);
            write_reg(tmr_pkg::REG_THRESHOLD, (ph % 5 == 0) ? 255 : (ph % 5 == 1) ? 0
                                               : $urandom_range(40, 0));
            run_frame(w, h, (ph % 3 == 2) ? 0 : 1);
            sent += w * h;
        end

        // tall narrow frame near the top of the height range, partial, then size change
        write_reg(tmr_pkg::REG_WIDTH, 2);
        write_reg(tmr_pkg::REG_HEIGHT, 65535);
        for (int i = 0; i < 20; i++) send_pixel(rand_pix(1));
        wait_idle();
        write_reg(tmr_pkg::REG_HEIGHT, 3);
        write_reg(tmr_pkg::REG_WIDTH, 0);
        for (int i = 0; i < 6; i++) send_pixel(rand_pix(0));
        wait_idle();
        write_reg(tmr_pkg::REG_WIDTH, 12'hfff);
        write_reg(tmr_pkg::REG_HEIGHT, 0);
        for (int i = 0; i < 4; i++) send_pixel(rand_pix(0));
        wait_idle();

        if (errors == 0 && pending_pix.size() == 0) begin
            $display("thresholded_median3x3_rgb test passed");
        end else begin
            $display("thresholded_median3x3_rgb test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tmr_pkg.sv
rtl/tmr_filter.sv
rtl/thresholded_median3x3_rgb.sv
bench/thresholded_median3x3_rgb_tb.sv
